FILE: hw/rtl/kdsl_pkg.sv
// Shared constants for the key debounce / short-long press block.
// No dependencies; used by key_debounce_short_long_press_top.
package kdsl_pkg;

   // Register map (word index into the CSR space)
   localparam logic [1:0] REG_SHAKE_TICKS = 2'd0;
   localparam logic [1:0] REG_SHORT_STEPS = 2'd1;
   localparam logic [1:0] REG_LONG_STEPS  = 2'd2;

   // Register reset values
   localparam logic [7:0] SHAKE_TICKS_RST = 8'd10;
   localparam logic [7:0] SHORT_STEPS_RST = 8'd3;
   localparam logic [7:0] LONG_STEPS_RST  = 8'd100;

   // Press event codes
   localparam logic [1:0] EV_NONE  = 2'd0;
   localparam logic [1:0] EV_SHORT = 2'd1;
   localparam logic [1:0] EV_LONG  = 2'd2;

endpackage

FILE: hw/rtl/key_debounce_short_long_press_top.sv
// Key debounce with short-press / long-press event detection, plus its CSRs.
// Depends on kdsl_pkg for the register map and event codes.
// The rsp word for an accepted req word is registered and appears in the cycle after it is taken.
// Throughput: 1 word per cycle while rsp_stall is low; a new word is taken while the previous result
// is being taken, since the result register refills in the cycle it drains.
// Reset (synchronous, active high): counters, arm flag, last level and rsp
// valid clear; CSRs return to shake 10, short 3, long 100.
module key_debounce_short_long_press_top (
   input  logic        clock,
   input  logic        reset,
   // scan tick input
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_pin_level,
   // event output
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_press_event,
   // CSR port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // CSRs
   logic [7:0] shake_ticks_ff;
   logic [7:0] short_steps_ff;
   logic [7:0] long_steps_ff;

   // debounce state
   logic       last_pressed_ff, last_pressed_in;
   logic [7:0] stable_ticks_ff, stable_ticks_in;
   logic [7:0] hold_steps_ff,   hold_steps_in;
   logic       short_armed_ff,  short_armed_in;

   // result register
   logic       rsp_valid_ff,    rsp_valid_in;
   logic [1:0] rsp_event_ff,    rsp_event_in;

   logic       csr_wr;
   logic [1:0] csr_idx;
   logic       req_take;

   logic       pressed;
   logic [7:0] hold_base;
   logic [7:0] stable_base;
   logic       armed_base;
   logic [7:0] stable_inc;
   logic [7:0] hold_inc;
   logic [7:0] hold_limit;
   logic       step_due;
   logic       step_adv;
   logic [1:0] ev;

   // CSR write/read
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         shake_ticks_ff <= kdsl_pkg::SHAKE_TICKS_RST;
         short_steps_ff <= kdsl_pkg::SHORT_STEPS_RST;
         long_steps_ff  <= kdsl_pkg::LONG_STEPS_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            kdsl_pkg::REG_SHAKE_TICKS: shake_ticks_ff <= csr_pwdata[7:0];
            kdsl_pkg::REG_SHORT_STEPS: short_steps_ff <= csr_pwdata[7:0];
            kdsl_pkg::REG_LONG_STEPS:  long_steps_ff  <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         kdsl_pkg::REG_SHAKE_TICKS: csr_prdata = {24'd0, shake_ticks_ff};
         kdsl_pkg::REG_SHORT_STEPS: csr_prdata = {24'd0, short_steps_ff};
         kdsl_pkg::REG_LONG_STEPS:  csr_prdata = {24'd0, long_steps_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   // handshake: result register refills when empty or draining
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   // debounce step for one scan tick
   always_comb begin
      pressed     = ~req_pin_level;
      ev          = kdsl_pkg::EV_NONE;
      // release clears counters and arm, may emit short press
      hold_base   = pressed ? hold_steps_ff : 8'd0;
      stable_base = pressed ? stable_ticks_ff : 8'd0;
      armed_base  = pressed && short_armed_ff;
      if (!pressed && short_armed_ff && (hold_steps_ff >= short_steps_ff)
          && (hold_steps_ff < long_steps_ff)) begin
         ev = kdsl_pkg::EV_SHORT;
      end

      hold_limit = (long_steps_ff != 8'hFF) ? long_steps_ff + 8'd1 : 8'hFF;
      stable_inc = stable_base + 8'd1;
      hold_inc   = hold_base + 8'd1;
      step_due   = (stable_inc >= shake_ticks_ff);
      step_adv   = step_due && (hold_base < hold_limit);

      stable_ticks_in = stable_base;
      hold_steps_in   = hold_base;
      short_armed_in  = armed_base;

      if (last_pressed_ff == pressed) begin
         stable_ticks_in = step_due ? 8'd0 : stable_inc;
         if (step_adv) begin
            hold_steps_in = hold_inc;
            if (pressed) begin
               if (hold_inc == short_steps_ff) short_armed_in = 1'b1;
               if (hold_inc == long_steps_ff)  ev = kdsl_pkg::EV_LONG;
            end
         end
      end else begin
         // level change restarts both counters
         stable_ticks_in = 8'd0;
         hold_steps_in   = 8'd0;
      end

      last_pressed_in = pressed;
      rsp_event_in    = ev;
      rsp_valid_in    = req_take || (rsp_valid_ff && rsp_stall);
   end

   // state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         last_pressed_ff <= 1'b0;
         stable_ticks_ff <= 8'd0;
         hold_steps_ff   <= 8'd0;
         short_armed_ff  <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            last_pressed_ff <= last_pressed_in;
            stable_ticks_ff <= stable_ticks_in;
            hold_steps_ff   <= hold_steps_in;
            short_armed_ff  <= short_armed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_event_ff <= rsp_event_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_press_event = rsp_event_ff;

endmodule
